FILE: rtl/exlex_pkg.sv
// Shared types, codes and constants for the expression lexer.
`timescale 1ns / 1ps

package exlex_pkg;

   // Width of the wrapping byte position counter.
   localparam int POSITION_BITS = 16;
   localparam int LEN_BITS      = 16;
   localparam int OFFSET_BITS   = 16;
   localparam int KW_BITS       = 40;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_BITS-1:0] LEN_ZERO = '0;
   localparam logic [LEN_BITS-1:0] LEN_ONE  = LEN_BITS'(1);
   localparam logic [LEN_BITS-1:0] LEN_TWO  = LEN_BITS'(2);
   localparam logic [LEN_BITS-1:0] LEN_MAX  = '1;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;

   localparam logic [KW_BITS-1:0] KW_IF    = 40'h00_0000_6966;
   localparam logic [KW_BITS-1:0] KW_FUN   = 40'h00_0066_756E;
   localparam logic [KW_BITS-1:0] KW_THEN  = 40'h00_7468_656E;
   localparam logic [KW_BITS-1:0] KW_ELSE  = 40'h00_656C_7365;
   localparam logic [KW_BITS-1:0] KW_TRUE  = 40'h00_7472_7565;
   localparam logic [KW_BITS-1:0] KW_FALSE = 40'h66_616C_7365;

   typedef enum logic [4:0] {
      KIND_IDENT   = 5'd0,
      KIND_INT     = 5'd1,
      KIND_TRUE    = 5'd2,
      KIND_FALSE   = 5'd3,
      KIND_IF      = 5'd4,
      KIND_THEN    = 5'd5,
      KIND_ELSE    = 5'd6,
      KIND_FUN     = 5'd7,
      KIND_PLUS    = 5'd8,
      KIND_MINUS   = 5'd9,
      KIND_STAR    = 5'd10,
      KIND_SLASH   = 5'd11,
      KIND_EQUAL   = 5'd12,
      KIND_EQQ     = 5'd13,
      KIND_NEQ     = 5'd14,
      KIND_LPAREN  = 5'd15,
      KIND_RPAREN  = 5'd16,
      KIND_COMMA   = 5'd17,
      KIND_ILLEGAL = 5'd18,
      KIND_EOF     = 5'd19
   } kind_type;

   // One token as it travels from the scanner to the output stage.
   typedef struct packed {
      kind_type                 kind;
      logic [OFFSET_BITS-1:0]   start_offset;
      logic [LEN_BITS-1:0]      length;
      logic                     last_of_run;
      logic [KW_BITS-1:0]       kw_chars;
   } token_type;

   // Up to two tokens written into the queue in one cycle.
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

endpackage

FILE: rtl/exlex_if.sv
// Handshake channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps

interface exlex_req_if
   import exlex_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface exlex_rsp_if
   import exlex_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [4:0]             kind;
   logic [OFFSET_BITS-1:0] start_offset;
   logic [LEN_BITS-1:0]    length;
   logic                   last_of_run;

   modport source (output valid, output kind, output start_offset, output length,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input start_offset, input length,
                   input last_of_run, output ready);
endinterface

FILE: rtl/expression_lexer_core.sv
// Top level of the streaming expression lexer.
//
//  channel  direction  word
//  req_bus  in         one source byte (ch); zero ends the text
//  rsp_bus  out        one token: kind, start_offset, length, last_of_run
//
// One byte is taken per cycle while at least two token queue entries are free.
// A byte that closes a token and also yields one (operator, end of text) puts
// two tokens in the four-entry queue; the output register drains one per cycle
// unless rsp_bus stalls. A closed token passes the queue, then the output register.
// Reset (synchronous) clears scan mode, byte position, queue and output valid.
// Output stalls back up through the queue to req_bus.ready.
`timescale 1ns / 1ps

module expression_lexer_core
   import exlex_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   exlex_req_if.sink     req_bus,
   exlex_rsp_if.source   rsp_bus
);

   push_type  push;
   logic      space_ok;
   logic      pop;
   logic      head_valid;
   token_type head_tok;

   exlex_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .space_ok (space_ok),
      .push     (push)
   );

   exlex_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space_ok   (space_ok),
      .pop        (pop),
      .head_valid (head_valid),
      .head_tok   (head_tok)
   );

   exlex_resolve u_resolve (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_tok   (head_tok),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

FILE: rtl/exlex_scan.sv
// Front end: accepts source bytes, tracks scan state and forms raw tokens.
`timescale 1ns / 1ps

module exlex_scan
   import exlex_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   exlex_req_if.sink    req_bus,
   input  logic         space_ok,
   output push_type     push
);

   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_INT   = 5'b00010,
      MODE_IDENT = 5'b00100,
      MODE_BANG  = 5'b01000,
      MODE_EQ    = 5'b10000
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic [KW_BITS-1:0]       kw_ff, kw_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [LEN_BITS-1:0]      len_ff, len_in, len_inc;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   logic       accept;
   logic [7:0] c;
   logic       is_digit, is_alpha, is_space, rescan;
   logic       t0_valid, t1_valid;
   token_type  t0, t1;

   function automatic kind_type op_kind(input logic [7:0] b);
      kind_type k;
      case (b)
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_STAR;
         CH_SLASH:  k = KIND_SLASH;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_COMMA:  k = KIND_COMMA;
         default:   k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   assign req_bus.ready = space_ok;
   assign accept        = req_bus.valid && space_ok;
   assign c             = req_bus.ch;

   assign is_digit = (c >= CH_0) && (c <= CH_9);
   assign is_alpha = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
   assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign len_inc  = (len_ff == LEN_MAX) ? len_ff : len_ff + LEN_ONE;

   always_comb begin
      mode_in  = mode_ff;
      kw_in    = kw_ff;
      start_in = start_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      rescan   = 1'b1;
      t0_valid = 1'b0;
      t1_valid = 1'b0;
      t0 = '{kind: KIND_INT, start_offset: OFFSET_BITS'(start_ff), length: len_ff,
             last_of_run: 1'b0, kw_chars: kw_ff};
      t1 = '{kind: KIND_EOF, start_offset: OFFSET_BITS'(pos_ff), length: LEN_ZERO,
             last_of_run: 1'b1, kw_chars: '0};

      // Close or extend the pending token.
      case (mode_ff)
         MODE_INT: begin
            if (is_digit) begin
               len_in = len_inc;
               rescan = 1'b0;
            end else begin
               t0_valid = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_digit || is_alpha) begin
               len_in = len_inc;
               kw_in  = {kw_ff[KW_BITS-9:0], c};
               rescan = 1'b0;
            end else begin
               t0_valid = 1'b1;
               t0.kind  = KIND_IDENT;
            end
         end
         MODE_BANG, MODE_EQ: begin
            t0_valid = 1'b1;
            if (c == CH_EQ) begin
               t0.kind   = (mode_ff == MODE_BANG) ? KIND_NEQ : KIND_EQQ;
               t0.length = LEN_TWO;
               mode_in   = MODE_IDLE;
               rescan    = 1'b0;
            end else begin
               t0.kind   = (mode_ff == MODE_BANG) ? KIND_ILLEGAL : KIND_EQUAL;
               t0.length = LEN_ONE;
            end
         end
         default: ;
      endcase

      if (c == CH_NUL) begin
         t1_valid = 1'b1;
         mode_in  = MODE_IDLE;
         len_in   = LEN_ZERO;
         pos_in   = '0;
      end else begin
         if (rescan) begin
            mode_in = MODE_IDLE;
            if (is_space) begin
               mode_in = MODE_IDLE;
            end else if (is_digit || is_alpha) begin
               mode_in  = is_digit ? MODE_INT : MODE_IDENT;
               start_in = pos_ff;
               len_in   = LEN_ONE;
               kw_in    = KW_BITS'(c);
            end else if (c == CH_BANG || c == CH_EQ) begin
               mode_in  = (c == CH_BANG) ? MODE_BANG : MODE_EQ;
               start_in = pos_ff;
               len_in   = LEN_ONE;
            end else begin
               t1_valid  = 1'b1;
               t1.kind   = op_kind(c);
               t1.length = LEN_ONE;
            end
         end
         pos_in = pos_ff + 1'b1;
      end

      // The later of the two tokens closes the run.
      t0.last_of_run = !t1_valid;
   end

   always_comb begin
      push.count = accept ? (2'(t0_valid) + 2'(t1_valid)) : 2'd0;
      push.tok0  = t0_valid ? t0 : t1;
      push.tok1  = t1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kw_ff    <= kw_in;
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

`ifndef SYNTHESIS
   a_eot_clears_pos: assert property (@(posedge clock) disable iff (reset)
      accept && c == CH_NUL |=> pos_ff == '0 && mode_ff == MODE_IDLE)
      else $error("end of text did not clear position and mode");
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> space_ok && req_bus.valid)
      else $error("token pushed without an accepted word");
   a_mode_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(mode_ff))
      else $error("scan mode is not one-hot");
`endif

endmodule

FILE: rtl/exlex_queue.sv
// Token queue between scanner and output stage: two writes, one read per cycle.
`timescale 1ns / 1ps

module exlex_queue
   import exlex_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      space_ok,
   input  logic      pop,
   output logic      head_valid,
   output token_type head_tok
);

   token_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0]     count_ff, count_in;
   logic [QPTR_BITS-1:0]     wptr_next;

   // Accept a byte only when both possible tokens fit.
   assign space_ok   = count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head_tok   = entry_ff[rptr_ff];
   assign wptr_next  = wptr_ff + 1'b1;

   always_comb begin
      wptr_in  = wptr_ff + QPTR_BITS'(push.count);
      rptr_in  = rptr_ff + QPTR_BITS'(pop);
      count_in = count_ff + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wptr_next] <= push.tok1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("token queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("token queue underflow");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wptr_ff == rptr_ff)
      else $error("empty queue with pointers apart");
`endif

endmodule

FILE: rtl/exlex_resolve.sv
// Back end: resolves keywords and drives the registered token output.
`timescale 1ns / 1ps

module exlex_resolve
   import exlex_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  token_type     head_tok,
   output logic          pop,
   exlex_rsp_if.source   rsp_bus
);

   logic                   valid_ff;
   kind_type               kind_ff, kind_in;
   logic [OFFSET_BITS-1:0] start_ff;
   logic [LEN_BITS-1:0]    len_ff;
   logic                   last_ff;
   logic                   load;

   function automatic kind_type ident_kind(input logic [LEN_BITS-1:0] len,
                                           input logic [KW_BITS-1:0] kw);
      kind_type k;
      k = KIND_IDENT;
      if (len == LEN_BITS'(2) && kw == KW_IF) k = KIND_IF;
      if (len == LEN_BITS'(3) && kw == KW_FUN) k = KIND_FUN;
      if (len == LEN_BITS'(4)) begin
         if (kw == KW_THEN) k = KIND_THEN;
         if (kw == KW_ELSE) k = KIND_ELSE;
         if (kw == KW_TRUE) k = KIND_TRUE;
      end
      if (len == LEN_BITS'(5) && kw == KW_FALSE) k = KIND_FALSE;
      return k;
   endfunction

   assign load = !valid_ff || rsp_bus.ready;
   assign pop  = load && head_valid;

   always_comb begin
      kind_in = head_tok.kind;
      if (head_tok.kind == KIND_IDENT) begin
         kind_in = ident_kind(head_tok.length, head_tok.kw_chars);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= kind_in;
         start_ff <= head_tok.start_offset;
         len_ff   <= head_tok.length;
         last_ff  <= head_tok.last_of_run;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.kind         = kind_ff;
   assign rsp_bus.start_offset = start_ff;
   assign rsp_bus.length       = len_ff;
   assign rsp_bus.last_of_run  = last_ff;

`ifndef SYNTHESIS
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_bus.ready |=> valid_ff)
      else $error("output word dropped while stalled");
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_bus.ready |=> $stable(kind_ff) && $stable(start_ff) &&
      $stable(len_ff) && $stable(last_ff))
      else $error("output word changed while stalled");
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("popped token not presented");
`endif

endmodule

FILE: sim/expression_lexer_core_tb.sv
// Self-checking testbench for the expression lexer: random byte streams vs. a token predictor.
`timescale 1ns / 1ps

module expression_lexer_core_tb;
   import exlex_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   typedef enum logic [2:0] {
      SCAN_IDLE = 3'd0,
      SCAN_INT  = 3'd1,
      SCAN_WORD = 3'd2,
      SCAN_BANG = 3'd3,
      SCAN_EQ   = 3'd4
   } scan_mode_type;

   typedef struct {
      kind_type               kind;
      logic [OFFSET_BITS-1:0] start;
      logic [LEN_BITS-1:0]    len;
      logic                   last;
   } token_rec_type;

   // Tracks the scanner state and the tokens still owed by the block.
   class token_ledger;
      scan_mode_type            mode;
      logic [KW_BITS-1:0]       kw;
      logic [OFFSET_BITS-1:0]   tok_start;
      logic [LEN_BITS-1:0]      tok_len;
      logic [POSITION_BITS-1:0] position;
      token_rec_type            tokens_due[$];
      int                       failures;

      function new();
         mode      = SCAN_IDLE;
         kw        = '0;
         tok_start = '0;
         tok_len   = '0;
         position  = '0;
         failures  = 0;
      endfunction

      function bit is_digit(input logic [7:0] c);
         return c >= CH_0 && c <= CH_9;
      endfunction

      function bit is_alpha(input logic [7:0] c);
         return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
      endfunction

      function void add(input kind_type k, input logic [OFFSET_BITS-1:0] s,
                        input logic [LEN_BITS-1:0] l);
         token_rec_type t;
         t.kind  = k;
         t.start = s;
         t.len   = l;
         t.last  = 1'b0;
         tokens_due.push_back(t);
      endfunction

      function kind_type word_kind();
         if (tok_len == LEN_TWO && kw == KW_IF) return KIND_IF;
         if (tok_len == 16'd3 && kw == KW_FUN) return KIND_FUN;
         if (tok_len == 16'd4) begin
            if (kw == KW_THEN) return KIND_THEN;
            if (kw == KW_ELSE) return KIND_ELSE;
            if (kw == KW_TRUE) return KIND_TRUE;
         end
         if (tok_len == 16'd5 && kw == KW_FALSE) return KIND_FALSE;
         return KIND_IDENT;
      endfunction

      // Scan a byte with no token pending.
      function void scan_fresh(input logic [7:0] c, input logic [POSITION_BITS-1:0] pos);
         kind_type k;
         mode = SCAN_IDLE;
         if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
         if (is_digit(c) || is_alpha(c)) begin
            mode      = is_digit(c) ? SCAN_INT : SCAN_WORD;
            tok_start = OFFSET_BITS'(pos);
            tok_len   = LEN_ONE;
            kw        = KW_BITS'(c);
            return;
         end
         if (c == CH_BANG || c == CH_EQ) begin
            mode      = (c == CH_BANG) ? SCAN_BANG : SCAN_EQ;
            tok_start = OFFSET_BITS'(pos);
            tok_len   = LEN_ONE;
            return;
         end
         case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_COMMA:  k = KIND_COMMA;
            default:   k = KIND_ILLEGAL;
         endcase
         add(k, OFFSET_BITS'(pos), LEN_ONE);
      endfunction

      function void take_byte(input logic [7:0] c);
         logic [POSITION_BITS-1:0] pos;
         bit                       rescan;
         int                       first;
         token_rec_type            t;
         first  = tokens_due.size();
         pos    = position;
         rescan = 1'b1;
         case (mode)
            SCAN_INT: begin
               if (c != CH_NUL && is_digit(c)) begin
                  if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
                  rescan = 1'b0;
               end else begin
                  add(KIND_INT, tok_start, tok_len);
               end
            end
            SCAN_WORD: begin
               if (c != CH_NUL && (is_alpha(c) || is_digit(c))) begin
                  if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
                  kw     = {kw[KW_BITS-9:0], c};
                  rescan = 1'b0;
               end else begin
                  add(word_kind(), tok_start, tok_len);
               end
            end
            SCAN_BANG, SCAN_EQ: begin
               if (c == CH_EQ) begin
                  add((mode == SCAN_BANG) ? KIND_NEQ : KIND_EQQ, tok_start, LEN_TWO);
                  mode   = SCAN_IDLE;
                  rescan = 1'b0;
               end else begin
                  add((mode == SCAN_BANG) ? KIND_ILLEGAL : KIND_EQUAL, tok_start, LEN_ONE);
               end
            end
            default: ;
         endcase
         if (c == CH_NUL) begin
            add(KIND_EOF, OFFSET_BITS'(pos), LEN_ZERO);
            mode     = SCAN_IDLE;
            tok_len  = LEN_ZERO;
            position = '0;
         end else begin
            if (rescan) scan_fresh(c, pos);
            position = pos + 1'b1;
         end
         // Flag the final token caused by this byte.
         if (tokens_due.size() > first) begin
            t      = tokens_due.pop_back();
            t.last = 1'b1;
            tokens_due.push_back(t);
         end
      endfunction

      function void match_token(input logic [4:0] kind, input logic [OFFSET_BITS-1:0] s,
                                input logic [LEN_BITS-1:0] l, input logic last);
         token_rec_type t;
         if (tokens_due.size() == 0) begin
            failures++;
            $display("%0t: token with none expected: kind %0d start %0d length %0d",
                     $time, kind, s, l);
            return;
         end
         t = tokens_due.pop_front();
         if (kind !== t.kind) begin
            failures++;
            $display("%0t: kind expected %0d actual %0d", $time, t.kind, kind);
         end
         if (s !== t.start) begin
            failures++;
            $display("%0t: start_offset expected %0d actual %0d", $time, t.start, s);
         end
         if (l !== t.len) begin
            failures++;
            $display("%0t: length expected %0d actual %0d", $time, t.len, l);
         end
         if (last !== t.last) begin
            failures++;
            $display("%0t: last_of_run expected %0d actual %0d", $time, t.last, last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   exlex_req_if req_bus ();
   exlex_rsp_if rsp_bus ();

   expression_lexer_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   token_ledger ledger;
   logic [7:0]  text_bytes[$];
   bit          idling = 1'b0;
   int          stall_left = 0;
   int          quiet_cycles = 0;
   string       keywords[6] = '{"if", "then", "else", "fun", "true", "false"};
   string       op_chars = "+-*/(),";

   always #5 clock = ~clock;

   // Receiver: stall in random bursts while idling is on.
   always @(negedge clock) begin
      if (stall_left > 0) stall_left = stall_left - 1;
      else if (idling && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 13);
      rsp_bus.ready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         ledger.match_token(rsp_bus.kind, rsp_bus.start_offset, rsp_bus.length,
                            rsp_bus.last_of_run);
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("expression_lexer_core_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function logic [7:0] rand_letter();
      if ($urandom_range(0, 1)) return 8'(CH_LA + $urandom_range(0, 25));
      return 8'(CH_UA + $urandom_range(0, 25));
   endfunction

   function logic [7:0] rand_alnum();
      if ($urandom_range(0, 3) == 0) return 8'(CH_0 + $urandom_range(0, 9));
      return rand_letter();
   endfunction

   function logic [7:0] space_char();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
   endfunction

   task push_text(input string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
   endtask

   task add_random_token();
      int n;
      case ($urandom_range(0, 13))
         0: push_text(keywords[$urandom_range(0, 5)]);
         1: begin
            // keyword with a tail: never a keyword
            push_text(keywords[$urandom_range(0, 5)]);
            n = $urandom_range(1, 3);
            repeat (n) text_bytes.push_back(rand_alnum());
         end
         2, 3: begin
            text_bytes.push_back(rand_letter());
            n = $urandom_range(0, 7);
            repeat (n) text_bytes.push_back(rand_alnum());
         end
         4: begin
            n = $urandom_range(1, 6);
            repeat (n) text_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
         end
         5: text_bytes.push_back(op_chars[$urandom_range(0, 6)]);
         6: push_text("==");
         7: push_text("!=");
         8: text_bytes.push_back(CH_EQ);
         9: text_bytes.push_back(CH_BANG);
         10, 11: begin
            n = $urandom_range(1, 3);
            repeat (n) text_bytes.push_back(space_char());
         end
         12: text_bytes.push_back(8'($urandom_range(0, 255)));
         default: text_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : CH_SPACE);
      endcase
      if ($urandom_range(0, 1)) text_bytes.push_back(space_char());
   endtask

   // Enter and leave at a falling edge; hold valid high between back-to-back words.
   task send_byte(input logic [7:0] c);
      int gap;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.ch    <= c;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      ledger.take_byte(c);
      @(negedge clock);
   endtask

   task send_text(input bit allow_idle);
      int sent;
      sent = 0;
      while (text_bytes.size() > 0) begin
         // switch idling on and off in stretches
         if (sent % 64 == 0) idling = allow_idle && ($urandom_range(0, 2) != 0);
         send_byte(text_bytes.pop_front());
         sent++;
      end
   endtask

   task wait_drained();
      while (ledger.tokens_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      ledger        = new();
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.ch    = CH_NUL;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Operators, keywords, lone bang, pending token ended by an operator and by end of text.
      push_text("if+fun-x9==!=!a=(7),then*else/true false\t=");
      text_bytes.push_back(8'hFF);
      push_text("!");
      text_bytes.push_back(CH_NUL);
      send_text(1'b1);

      // hold off until the block has drained
      req_bus.valid <= 1'b0;
      wait_drained();

      while (text_bytes.size() < 850) add_random_token();
      text_bytes.push_back(CH_NUL);
      send_text(1'b1);

      // No idling from here on.
      push_text("+x 1,");
      repeat (60) add_random_token();
      text_bytes.push_back(CH_NUL);
      send_text(1'b0);
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (ledger.failures == 0 && ledger.tokens_due.size() == 0)
         $display("expression_lexer_core_tb passed");
      else
         $display("expression_lexer_core_tb failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/exlex_pkg.sv
rtl/exlex_if.sv
rtl/exlex_scan.sv
rtl/exlex_queue.sv
rtl/exlex_resolve.sv
rtl/expression_lexer_core.sv
sim/expression_lexer_core_tb.sv
